>>> hw/rtl/round_robin_task_scheduler_unit_macros.svh
// Assertion macros for the round-robin task scheduler.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_UNIT_MACROS_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define RRTS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RRTS_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RRTS_ASSERT(label, clk, rst, prop, msg)
`define RRTS_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

>>> hw/rtl/rrts_pkg.sv
package rrts_pkg;
  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_CREATE = 3'd1;
  localparam logic [2:0] CMD_SLEEP  = 3'd2;
  localparam logic [2:0] CMD_EXIT   = 3'd3;
  localparam logic [2:0] CMD_WAIT   = 3'd4;
  localparam logic [2:0] CMD_SCHED  = 3'd5;

  localparam logic [2:0] ST_FREE  = 3'd0;
  localparam logic [2:0] ST_RUN   = 3'd1;
  localparam logic [2:0] ST_SLEEP = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;
  localparam logic [2:0] ST_DEAD  = 3'd4;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_NONE = 2'd2;

  typedef logic [2:0] command_t;
  typedef logic [1:0] status_t;
endpackage

>>> hw/rtl/round_robin_task_scheduler_unit.sv
// Round-robin task table. One command per transfer, one result per command. Slot state
// (status, ring link, parent, wake time) lives in one synchronous memory, so every slot
// visit is a read state followed by a check or write-back state. After reset a clearing
// pass over every slot initialises the table with in_stall high. Input is stalled from
// the transfer until the result is issued. Tick and unknown commands go straight to the
// result; create scans for the lowest free slot. Schedule runs a reap, a wake and a
// select pass over the ring, and every dead slot it frees adds a full pass over the table
// to unlink its children. Wait first walks the ring for a live child and, if it finds
// one, parks the running task and runs a schedule. A stalled result holds the block in
// its final state until it is taken.
`include "round_robin_task_scheduler_unit_macros.svh"
module round_robin_task_scheduler_unit #(
  parameter int MAX_TASKS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  rrts_pkg::command_t  command,
  input  logic                with_parent,
  input  logic [31:0]         sleep_ticks,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [3:0]          current_task,
  output logic [3:0]          new_task,
  output logic [31:0]         pid_value,
  output rrts_pkg::status_t   status_code,
  output logic                switched
);
  import rrts_pkg::*;

  localparam int SW = $clog2(MAX_TASKS);
  localparam int PW = $clog2(MAX_TASKS + 1);
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int EW = 3 + SW + PW + 64;
  localparam logic [PW-1:0] NO_PARENT = PW'(MAX_TASKS);

  typedef struct packed {
    logic [2:0]    st;
    logic [SW-1:0] link;
    logic [PW-1:0] par;
    logic [63:0]   wake;
  } entry_t;

  localparam logic [4:0] S_INIT   = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_CUR_RD = 5'd2;
  localparam logic [4:0] S_CUR_OP = 5'd3;
  localparam logic [4:0] S_CR_RD  = 5'd4;
  localparam logic [4:0] S_CR_CHK = 5'd5;
  localparam logic [4:0] S_CC_RD  = 5'd6;
  localparam logic [4:0] S_CC_WR  = 5'd7;
  localparam logic [4:0] S_CN_WR  = 5'd8;
  localparam logic [4:0] S_WT_RD  = 5'd9;
  localparam logic [4:0] S_WT_CHK = 5'd10;
  localparam logic [4:0] S_PK_RD  = 5'd11;
  localparam logic [4:0] S_PK_WR  = 5'd12;
  localparam logic [4:0] S_RP_RD  = 5'd13;
  localparam logic [4:0] S_RP_CHK = 5'd14;
  localparam logic [4:0] S_RL_RD  = 5'd15;
  localparam logic [4:0] S_RL_WR  = 5'd16;
  localparam logic [4:0] S_PA_RD  = 5'd17;
  localparam logic [4:0] S_PA_WR  = 5'd18;
  localparam logic [4:0] S_UL_RD  = 5'd19;
  localparam logic [4:0] S_UL_CHK = 5'd20;
  localparam logic [4:0] S_FR_WR  = 5'd21;
  localparam logic [4:0] S_WK_RD  = 5'd22;
  localparam logic [4:0] S_WK_CHK = 5'd23;
  localparam logic [4:0] S_SH_RD  = 5'd24;
  localparam logic [4:0] S_SH_CHK = 5'd25;
  localparam logic [4:0] S_SL_RD  = 5'd26;
  localparam logic [4:0] S_SL_CHK = 5'd27;
  localparam logic [4:0] S_DONE   = 5'd28;

  logic [EW-1:0] mem [MAX_TASKS];
  logic [EW-1:0] rd_raw;
  entry_t        rd;
  logic [SW-1:0] rd_addr;
  logic          wr_en;
  logic [SW-1:0] wr_addr;
  entry_t        wr_data;

  logic [4:0]    state;
  logic [SW-1:0] running;
  logic [63:0]   tick;
  logic [31:0]   pid_counter;
  command_t      cmd;
  logic          wp;
  logic [31:0]   sticks;
  logic [SW-1:0] ptr;
  logic [SW-1:0] prev;
  logic [SW-1:0] nx;
  logic [SW-1:0] victim;
  logic [SW-1:0] idx;
  logic [PW-1:0] par_hold;
  logic [CW-1:0] steps;
  logic [SW-1:0] new_slot;
  logic [SW-1:0] init_cnt;
  logic [3:0]    r_new;
  logic [31:0]   r_pid;
  status_t       r_stat;
  logic          r_sw;
  logic          load;

  assign rd = entry_t'(rd_raw);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= EW'(wr_data);
    end
    rd_raw <= mem[rd_addr];
  end

  assign in_stall = (state != S_IDLE);
  assign load     = (state == S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr;
    wr_data = rd;
    case (state)
      S_INIT: begin
        wr_en   = 1'b1;
        wr_addr = init_cnt;
        wr_data = '{st: (init_cnt == '0) ? ST_RUN : ST_FREE, link: init_cnt,
                    par: NO_PARENT, wake: 64'd0};
      end
      S_CUR_OP: begin
        wr_addr = running;
        if (cmd == CMD_SLEEP) begin
          wr_en        = 1'b1;
          wr_data.st   = ST_SLEEP;
          wr_data.wake = tick + {32'd0, sticks};
        end else if (cmd == CMD_EXIT) begin
          wr_en      = 1'b1;
          wr_data.st = ST_DEAD;
        end
      end
      S_CC_WR: begin
        wr_en        = 1'b1;
        wr_addr      = running;
        wr_data.link = new_slot;
      end
      S_CN_WR: begin
        wr_en   = 1'b1;
        wr_addr = new_slot;
        wr_data = '{st: ST_RUN, link: nx, par: wp ? PW'(running) : NO_PARENT,
                    wake: 64'd0};
      end
      S_PK_WR: begin
        wr_en      = 1'b1;
        wr_addr    = running;
        wr_data.st = ST_WAIT;
      end
      S_RL_WR: begin
        wr_en        = 1'b1;
        wr_addr      = prev;
        wr_data.link = nx;
      end
      S_PA_WR: begin
        wr_en      = (rd.st == ST_WAIT);
        wr_addr    = SW'(par_hold);
        wr_data.st = ST_RUN;
      end
      S_UL_CHK: begin
        wr_en       = (rd.par == PW'(victim));
        wr_addr     = idx;
        wr_data.par = NO_PARENT;
      end
      S_FR_WR: begin
        wr_en   = 1'b1;
        wr_addr = victim;
        wr_data = '{st: ST_FREE, link: victim, par: NO_PARENT, wake: 64'd0};
      end
      S_WK_CHK: begin
        wr_en      = (rd.st == ST_SLEEP) && (rd.wake <= tick);
        wr_addr    = ptr;
        wr_data.st = ST_RUN;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      running     <= '0;
      tick        <= '0;
      pid_counter <= 32'd1;
      init_cnt    <= '0;
      rd_addr     <= '0;
    end else begin
      case (state)
        S_INIT: begin
          init_cnt <= init_cnt + 1'b1;
          if (32'(init_cnt) == MAX_TASKS - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd    <= command;
            wp     <= with_parent;
            sticks <= sleep_ticks;
            r_new  <= '0;
            r_pid  <= '0;
            r_stat <= STAT_OK;
            r_sw   <= 1'b0;
            case (command)
              CMD_TICK: begin
                tick  <= tick + 64'd1;
                state <= S_DONE;
              end
              CMD_CREATE: begin
                ptr     <= '0;
                rd_addr <= '0;
                state   <= S_CR_RD;
              end
              CMD_SLEEP, CMD_EXIT, CMD_WAIT, CMD_SCHED: begin
                rd_addr <= running;
                state   <= S_CUR_RD;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_CUR_RD: state <= S_CUR_OP;
        S_CUR_OP: begin
          if (cmd == CMD_WAIT) begin
            ptr     <= rd.link;
            rd_addr <= rd.link;
            steps   <= '0;
            state   <= S_WT_RD;
          end else if (cmd == CMD_SCHED) begin
            r_sw    <= 1'b1;
            prev    <= running;
            ptr     <= rd.link;
            rd_addr <= rd.link;
            steps   <= '0;
            state   <= S_RP_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_CR_RD: state <= S_CR_CHK;
        S_CR_CHK: begin
          if (rd.st == ST_FREE) begin
            new_slot <= ptr;
            rd_addr  <= running;
            state    <= S_CC_RD;
          end else if (32'(ptr) == MAX_TASKS - 1) begin
            r_stat <= STAT_FULL;
            state  <= S_DONE;
          end else begin
            ptr     <= ptr + 1'b1;
            rd_addr <= ptr + 1'b1;
            state   <= S_CR_RD;
          end
        end
        S_CC_RD: state <= S_CC_WR;
        S_CC_WR: begin
          nx    <= rd.link;
          r_new <= 4'(new_slot);
          if (wp) begin
            r_pid       <= pid_counter;
            pid_counter <= pid_counter + 32'd1;
          end
          state <= S_CN_WR;
        end
        S_CN_WR: state <= S_DONE;
        S_WT_RD: state <= S_WT_CHK;
        S_WT_CHK: begin
          if (ptr == running || 32'(steps) >= MAX_TASKS) begin
            state <= S_DONE;
          end else if (rd.par == PW'(running) && rd.st != ST_DEAD) begin
            rd_addr <= running;
            state   <= S_PK_RD;
          end else begin
            ptr     <= rd.link;
            rd_addr <= rd.link;
            steps   <= steps + 1'b1;
            state   <= S_WT_RD;
          end
        end
        S_PK_RD: state <= S_PK_WR;
        S_PK_WR: begin
          r_sw    <= 1'b1;
          prev    <= running;
          ptr     <= rd.link;
          rd_addr <= rd.link;
          steps   <= '0;
          state   <= S_RP_RD;
        end
        S_RP_RD: state <= S_RP_CHK;
        S_RP_CHK: begin
          if (ptr == running || 32'(steps) >= MAX_TASKS) begin
            ptr     <= running;
            rd_addr <= running;
            steps   <= '0;
            state   <= S_WK_RD;
          end else if (rd.st == ST_DEAD) begin
            victim   <= ptr;
            nx       <= rd.link;
            par_hold <= rd.par;
            rd_addr  <= prev;
            state    <= S_RL_RD;
          end else begin
            prev    <= ptr;
            ptr     <= rd.link;
            rd_addr <= rd.link;
            steps   <= steps + 1'b1;
            state   <= S_RP_RD;
          end
        end
        S_RL_RD: state <= S_RL_WR;
        S_RL_WR: begin
          if (par_hold < NO_PARENT) begin
            rd_addr <= SW'(par_hold);
            state   <= S_PA_RD;
          end else begin
            idx     <= '0;
            rd_addr <= '0;
            state   <= S_UL_RD;
          end
        end
        S_PA_RD: state <= S_PA_WR;
        S_PA_WR: begin
          idx     <= '0;
          rd_addr <= '0;
          state   <= S_UL_RD;
        end
        S_UL_RD: state <= S_UL_CHK;
        S_UL_CHK: begin
          if (32'(idx) == MAX_TASKS - 1) begin
            state <= S_FR_WR;
          end else begin
            idx     <= idx + 1'b1;
            rd_addr <= idx + 1'b1;
            state   <= S_UL_RD;
          end
        end
        S_FR_WR: begin
          ptr     <= nx;
          rd_addr <= nx;
          steps   <= steps + 1'b1;
          state   <= S_RP_RD;
        end
        S_WK_RD: state <= S_WK_CHK;
        S_WK_CHK: begin
          if (rd.link == running || 32'(steps) + 1 >= MAX_TASKS) begin
            rd_addr <= running;
            state   <= S_SH_RD;
          end else begin
            ptr     <= rd.link;
            rd_addr <= rd.link;
            steps   <= steps + 1'b1;
            state   <= S_WK_RD;
          end
        end
        S_SH_RD: state <= S_SH_CHK;
        S_SH_CHK: begin
          ptr     <= rd.link;
          rd_addr <= rd.link;
          steps   <= '0;
          state   <= S_SL_RD;
        end
        S_SL_RD: state <= S_SL_CHK;
        S_SL_CHK: begin
          if (rd.st == ST_RUN) begin
            running <= ptr;
            state   <= S_DONE;
          end else if (ptr == running || 32'(steps) + 1 >= MAX_TASKS) begin
            r_stat <= STAT_NONE;
            state  <= S_DONE;
          end else begin
            steps   <= steps + 1'b1;
            ptr     <= rd.link;
            rd_addr <= rd.link;
            state   <= S_SL_RD;
          end
        end
        S_DONE: begin
          if (load) begin
            current_task <= 4'(running);
            new_task     <= r_new;
            pid_value    <= r_pid;
            status_code  <= r_stat;
            switched     <= r_sw;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `RRTS_ASSERT(a_stall_busy, clk, rst, out_valid && out_stall |=> out_valid, "result lost")
  `RRTS_ASSERT(a_stall_hold, clk, rst, out_valid && out_stall |=> $stable(pid_value), "pid moved")
  `RRTS_ASSERT(a_run_range, clk, rst, 32'(running) < MAX_TASKS, "running slot out of range")
  `RRTS_ASSERT(a_full_slot, clk, rst, out_valid && status_code == STAT_FULL |-> new_task == '0, "full gave slot")
endmodule
